[src/indexed_list_store_core_macros.svh]
// Assertion macros used by the checker file.
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define ILS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Types and constants of the indexed list store: beat payloads, action
// codes and the command broadcast to the cell chain.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int ACT_W        = 3;
    localparam int POS_W        = 8;
    localparam int DATA_W       = 32;
    localparam int LEN_W        = 5;

    localparam logic [ACT_W-1:0] ACT_GET    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_INDEX  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic                     done_res;
        logic [LEN_W-1:0]         length;
    } out_item_t;

    typedef enum logic [1:0] {
        SHIFT_HOLD,
        SHIFT_INSERT,
        SHIFT_DELETE
    } shift_op_t;

    typedef struct packed {
        shift_op_t          op;
        logic [POS_W-1:0]   position;
        logic [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

[src/ils_cell.sv]
// ----------------------------------------------------------------------------
// ils_cell
// One entry of the store. Loads the new value, takes the left neighbor on an
// insert below it, takes the right neighbor on a delete at or below it.
// ----------------------------------------------------------------------------
module ils_cell #(
    parameter int INDEX = 0
) (
    input  logic                       aclk,
    input  ils_pkg::cell_cmd_t         cmd,
    input  logic [ils_pkg::DATA_W-1:0] left_in,
    input  logic [ils_pkg::DATA_W-1:0] right_in,
    output logic [ils_pkg::DATA_W-1:0] value_out,
    output logic [ils_pkg::DATA_W-1:0] read_out
);

    localparam logic [ils_pkg::POS_W:0] IDX = (ils_pkg::POS_W + 1)'(INDEX);

    logic [ils_pkg::DATA_W-1:0] value_reg;
    logic [ils_pkg::POS_W:0]    pos_ext;

    assign pos_ext   = {1'b0, cmd.position};
    assign value_out = value_reg;
    assign read_out  = (pos_ext == IDX) ? value_reg : '0;

    always_ff @(posedge aclk) begin
        case (cmd.op)
            ils_pkg::SHIFT_INSERT: begin
                if (IDX == pos_ext) begin
                    value_reg <= cmd.value;
                end else if (IDX > pos_ext) begin
                    value_reg <= left_in;
                end
            end
            ils_pkg::SHIFT_DELETE: begin
                if (IDX >= pos_ext) begin
                    value_reg <= right_in;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[src/ils_ctrl.sv]
// ----------------------------------------------------------------------------
// ils_ctrl
// Command decode and entry count. Checks range and room, drives the shift
// command to the cells and reports hit and new count.
// ----------------------------------------------------------------------------
module ils_ctrl #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                fire,
    input  ils_pkg::in_item_t                   item,
    output ils_pkg::cell_cmd_t                  cmd,
    output logic                                is_get,
    output logic                                ok,
    output logic [$clog2(CAPACITY + 1)-1:0]     count_next
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ils_pkg::POS_W + 1;

    logic [CNT_W-1:0] count_reg;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_ext;
    logic             room;
    logic             in_range;
    ils_pkg::shift_op_t op;
    logic [ils_pkg::POS_W-1:0] tgt;

    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = {1'b0, item.position};
    assign room     = count_reg < CNT_W'(CAPACITY);
    assign in_range = pos_ext < cnt_ext;

    always_comb begin
        is_get = 1'b0;
        ok     = 1'b0;
        op     = ils_pkg::SHIFT_HOLD;
        tgt    = item.position;
        case (item.action)
            ils_pkg::ACT_GET: begin
                is_get = 1'b1;
                ok     = in_range;
            end
            ils_pkg::ACT_HEAD: begin
                ok  = room;
                op  = ils_pkg::SHIFT_INSERT;
                tgt = '0;
            end
            ils_pkg::ACT_TAIL: begin
                ok  = room;
                op  = ils_pkg::SHIFT_INSERT;
                tgt = ils_pkg::POS_W'(count_reg);
            end
            ils_pkg::ACT_INDEX: begin
                ok = room && (pos_ext <= cnt_ext);
                op = ils_pkg::SHIFT_INSERT;
            end
            ils_pkg::ACT_DELETE: begin
                ok = in_range;
                op = ils_pkg::SHIFT_DELETE;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        cmd.op       = (fire && ok) ? op : ils_pkg::SHIFT_HOLD;
        cmd.position = tgt;
        cmd.value    = item.item_value;
        count_next   = count_reg;
        if (ok && op == ils_pkg::SHIFT_INSERT) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ok && op == ils_pkg::SHIFT_DELETE) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (fire) begin
            count_reg <= count_next;
        end
    end

endmodule

[src/indexed_list_store_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered store of up to CAPACITY signed 32-bit values built as a chain of
// cells; get, insert at head, tail or index, and delete at index.
// ----------------------------------------------------------------------------
// Input beats arrive on s_valid/s_ready/s_data, one result beat per command
// leaves on m_valid/m_ready/m_data.
// Output: the result is registered and appears in the cycle after the input
// beat is taken.
// Throughput: one command per cycle while m_ready stays high. The cells at and
// above the position update in the same cycle, so inserts and deletes cost the
// same at any position; a get reads through the select of the cell outputs.
// Stall: while a result waits with m_ready low, s_ready stays low and the
// input beat is held upstream; no result is dropped.
// Reset: aresetn clears the entry count and the output valid; the cell
// contents are not cleared and are only read below the count.
// Misses, full inserts and out-of-range positions leave the store as is and
// return done_res low (read_value -1 for a get miss, 0 otherwise).
// ----------------------------------------------------------------------------
module indexed_list_store_core #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ils_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output ils_pkg::out_item_t m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    ils_pkg::cell_cmd_t         cmd;
    logic                       fire;
    logic                       is_get;
    logic                       ok;
    logic [CNT_W-1:0]           count_next;
    logic [ils_pkg::DATA_W-1:0] cell_q  [CAPACITY];
    logic [ils_pkg::DATA_W-1:0] cell_rd [CAPACITY];
    logic [ils_pkg::DATA_W-1:0] sel_value;
    ils_pkg::out_item_t         result;
    ils_pkg::out_item_t         m_data_reg;
    logic                       m_valid_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign fire    = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    ils_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fire       (fire),
        .item       (s_data),
        .cmd        (cmd),
        .is_get     (is_get),
        .ok         (ok),
        .count_next (count_next)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ils_pkg::DATA_W-1:0] left_in;
        logic [ils_pkg::DATA_W-1:0] right_in;
        if (i == 0) begin : g_first
            assign left_in = '0;
        end else begin : g_mid_l
            assign left_in = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_in = '0;
        end else begin : g_mid_r
            assign right_in = cell_q[i+1];
        end
        ils_cell #(
            .INDEX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .left_in   (left_in),
            .right_in  (right_in),
            .value_out (cell_q[i]),
            .read_out  (cell_rd[i])
        );
    end

    always_comb begin
        sel_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            sel_value = sel_value | cell_rd[i];
        end
    end

    always_comb begin
        result.read_value = '0;
        if (is_get) begin
            result.read_value = ok ? $signed(sel_value) : ils_pkg::MISS_VALUE;
        end
        result.done_res = ok;
        result.length   = ils_pkg::LEN_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_data_reg <= result;
        end
    end

endmodule

[src/ils_checker.sv]
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the indexed list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_macros.svh"

module ils_checker #(
    parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input ils_pkg::out_item_t m_data
);

    logic s_fire;
    logic m_stall;
    logic len_ok;
    logic miss_ok;

    assign s_fire  = s_valid && s_ready;
    assign m_stall = m_valid && !m_ready;
    assign len_ok  = (CAPACITY >= 32) || (int'(m_data.length) <= CAPACITY);
    assign miss_ok = m_data.done_res || (m_data.read_value == '0)
                     || (m_data.read_value == ils_pkg::MISS_VALUE);

    `ILS_ASSERT_NEXT(a_result_holds, m_stall, m_valid && $stable(m_data), "beat changed in stall")
    `ILS_ASSERT_NEXT(a_one_result, s_fire, m_valid, "no result beat after a command")
    `ILS_ASSERT_NOW(a_ready_free, !s_ready, m_stall, "input stalled without a waiting result")
    `ILS_ASSERT_NOW(a_length_cap, m_valid, len_ok, "length beyond capacity")
    `ILS_ASSERT_NOW(a_fail_value, m_valid, miss_ok, "failed command with bad read value")

endmodule

bind indexed_list_store_core ils_checker #(
    .CAPACITY (CAPACITY)
) u_ils_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
